/* sv/pbr_pkg.sv */
// Shared types and constants for the polynomial bisection root finder.
// Used by pbr_mul32, poly_bisection_root and the bench; depends on nothing else.
package pbr_pkg;

	// Polynomial shape and iteration limit.
	localparam int DEGREE   = 4;
	localparam int NUM_COEF = DEGREE + 1;
	localparam int K_W      = $clog2(NUM_COEF);
	localparam int MAX_ITER = 64;
	localparam int ITER_W   = 7;

	// Configuration register indexes.
	localparam logic [2:0] REG_COEF_X4 = 3'd0;
	localparam logic [2:0] REG_COEF_X3 = 3'd1;
	localparam logic [2:0] REG_COEF_X2 = 3'd2;
	localparam logic [2:0] REG_COEF_X1 = 3'd3;
	localparam logic [2:0] REG_COEF_X0 = 3'd4;
	localparam logic [2:0] REG_TOL     = 3'd5;

	// Register reset values.
	localparam logic signed [31:0] COEF_X4_RST = 32'sd83886080;
	localparam logic signed [31:0] COEF_X3_RST = -32'sd375809638;
	localparam logic signed [31:0] COEF_X2_RST = 32'sd265964436;
	localparam logic signed [31:0] COEF_X1_RST = 32'sd405371015;
	localparam logic signed [31:0] COEF_X0_RST = -32'sd393967587;
	localparam logic [31:0]        TOL_RST     = 32'd429497;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BRACKET = 2'd1;
	localparam logic [1:0] ST_CAP     = 2'd2;

	// Symmetric saturation limits of the Q24.40 accumulator.
	localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0001;

	// Request to the shared multiplier.
	typedef struct packed {
		logic        en;
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

endpackage

/* sv/pbr_mul32.sv */
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on pbr_pkg for the request struct.
module pbr_mul32 (
	input  logic              clk,
	input  pbr_pkg::mul_req_t req,
	output logic [63:0]       prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

	assign prod = prod_q;

endmodule

/* sv/poly_bisection_root.sv */
// Top level of the polynomial bisection root finder: sequencer and datapath.
// Depends on pbr_pkg and on pbr_mul32, the one multiplier that all products share.
//
// Usage:
// A bracket (left_end, right_end) in signed Q8.24 is taken at a rising edge with
// start high and busy low. busy stays high until the result has been produced.
// The result (root, status, iterations) appears for exactly one cycle with done
// high; the receiver has to take it in that cycle, it cannot stall the block.
// Configuration: wr_en, wr_index and wr_data write one register per cycle
// (0..4 the coefficients of x^4 down to x^0, 5 the tolerance); other indexes
// are ignored. Write only while busy is low.
// Operation: each polynomial evaluation is four Horner steps on the shared
// multiplier (magnitude, low product, high product, rescale, saturating add)
// plus setup and sign check. Both endpoints are evaluated first; a wrong
// bracket ends there, an already converged one after the first stop test, and
// otherwise each halving and its evaluation are followed by the stop test, up
// to 64 halvings. A new bracket is accepted in the done cycle.
// Reset clears the sequencer and loads the default coefficients and tolerance.
module poly_bisection_root (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] left_end,
	input  logic signed [31:0] right_end,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	output logic               done,
	output logic signed [31:0] root,
	output logic [1:0]         status,
	output logic [6:0]         iterations
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_SETUP  = 12'b0000_0000_0010,
		S_ABS    = 12'b0000_0000_0100,
		S_MLO    = 12'b0000_0000_1000,
		S_MHI    = 12'b0000_0001_0000,
		S_RND    = 12'b0000_0010_0000,
		S_ADD    = 12'b0000_0100_0000,
		S_EVDONE = 12'b0000_1000_0000,
		S_TABS   = 12'b0001_0000_0000,
		S_TMUL   = 12'b0010_0000_0000,
		S_TCMP   = 12'b0100_0000_0000,
		S_HALVE  = 12'b1000_0000_0000
	} state_t;

	typedef enum logic [2:0] {
		PH_LEFT  = 3'b001,
		PH_RIGHT = 3'b010,
		PH_MID   = 3'b100
	} phase_t;

	// Control state.
	state_t                          state_q, state_d;
	phase_t                          phase_q;
	logic [pbr_pkg::K_W-1:0]         k_q;
	logic [pbr_pkg::ITER_W-1:0]      iter_q;
	logic                            done_q;
	logic                            fl_neg_q;
	logic                            fl_zero_q;
	logic signed [31:0]              coef_q [pbr_pkg::NUM_COEF];
	logic [31:0]                     tol_q;

	// Datapath registers.
	logic [31:0] left_q, right_q, x_q, mid_q, prev_q;
	logic [31:0] bmag_q, mmag_q;
	logic        xneg_q, pneg_q;
	logic [63:0] acc_q, plo_q;
	logic [62:0] amag_q, r_q;
	logic [32:0] dif_q, dmag_q;
	logic [31:0] root_q;
	logic [1:0]  status_q;
	logic [pbr_pkg::ITER_W-1:0] iter_out_q;

	// Combinational datapath.
	pbr_pkg::mul_req_t mul_req;
	logic [63:0] mul_prod;
	logic [63:0] acc_neg, acc_init, sum64, acc_add;
	logic [62:0] amag_d, r_d;
	logic [64:0] coef_ext, t65;
	logic        hi_ovf, lo_ovf;
	logic        fneg, fzero, bad_bracket, conv;
	logic [32:0] sum33, dif_d, dmag_d;
	logic [39:0] d100;
	logic [31:0] xmag_d, mmag_d;
	logic        finish;
	logic [1:0]  fin_status;
	logic [31:0] fin_root;

	pbr_mul32 u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (mul_prod)
	);

	always_comb begin
		mul_req.en = 1'b0;
		mul_req.a  = amag_q[31:0];
		mul_req.b  = bmag_q;
		case (state_q)
			S_MLO: begin
				mul_req.en = 1'b1;
			end
			S_MHI: begin
				mul_req.en = 1'b1;
				mul_req.a  = {1'b0, amag_q[62:32]};
			end
			S_TMUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = tol_q;
				mul_req.b  = mmag_q;
			end
			default: begin
				mul_req.en = 1'b0;
			end
		endcase
	end

	always_comb begin
		// Horner setup and magnitude of the accumulator.
		acc_init = {{16{coef_q[pbr_pkg::NUM_COEF-1][31]}},
			coef_q[pbr_pkg::NUM_COEF-1], 16'h0000};
		xmag_d   = x_q[31] ? (32'h0 - x_q) : x_q;
		acc_neg  = 64'h0 - acc_q;
		amag_d   = acc_q[63] ? acc_neg[62:0] : acc_q[62:0];

		// Rescale the 95-bit product by 2^-24 and limit it to 2^63-1.
		sum64 = {1'b0, mul_prod[54:0], 8'h00} + {24'h000000, plo_q[63:24]};
		r_d   = ((|mul_prod[63:55]) || sum64[63]) ? pbr_pkg::SAT_POS[62:0] : sum64[62:0];

		// Saturating add of the next coefficient.
		coef_ext = {{17{coef_q[k_q][31]}}, coef_q[k_q], 16'h0000};
		t65      = pneg_q ? (coef_ext - {2'b00, r_q}) : (coef_ext + {2'b00, r_q});
		hi_ovf   = !t65[64] && t65[63];
		lo_ovf   = t65[64] && (!t65[63] || !(|t65[62:0]));
		if (hi_ovf) begin
			acc_add = pbr_pkg::SAT_POS;
		end else if (lo_ovf) begin
			acc_add = pbr_pkg::SAT_NEG;
		end else begin
			acc_add = t65[63:0];
		end

		fneg        = acc_q[63];
		fzero       = !(|acc_q);
		bad_bracket = fl_zero_q || fzero || (fl_neg_q == fneg);

		// Stop test: 100*|mid-prev| * 2^32 < tolerance*|mid|.
		mmag_d = mid_q[31] ? (32'h0 - mid_q) : mid_q;
		dif_d  = {mid_q[31], mid_q} - {prev_q[31], prev_q};
		dmag_d = dif_q[32] ? (33'h0 - dif_q) : dif_q;
		d100   = ({7'h00, dmag_q} << 6) + ({7'h00, dmag_q} << 5) + ({7'h00, dmag_q} << 2);
		conv   = !(|d100[39:32]) && ({d100[31:0], 32'h0} < mul_prod);

		sum33 = {left_q[31], left_q} + {right_q[31], right_q};
	end

	always_comb begin
		state_d    = state_q;
		finish     = 1'b0;
		fin_status = pbr_pkg::ST_OK;
		fin_root   = mid_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SETUP;
				end
			end
			S_SETUP:  state_d = S_ABS;
			S_ABS:    state_d = S_MLO;
			S_MLO:    state_d = S_MHI;
			S_MHI:    state_d = S_RND;
			S_RND:    state_d = S_ADD;
			S_ADD: begin
				state_d = (k_q == '0) ? S_EVDONE : S_ABS;
			end
			S_EVDONE: begin
				case (phase_q)
					PH_LEFT: begin
						state_d = S_SETUP;
					end
					PH_RIGHT: begin
						if (bad_bracket) begin
							state_d    = S_IDLE;
							finish     = 1'b1;
							fin_status = pbr_pkg::ST_BRACKET;
							fin_root   = 32'h0;
						end else begin
							state_d = S_TABS;
						end
					end
					default: begin
						if (fzero) begin
							state_d = S_IDLE;
							finish  = 1'b1;
						end else begin
							state_d = S_TABS;
						end
					end
				endcase
			end
			S_TABS:   state_d = S_TMUL;
			S_TMUL:   state_d = S_TCMP;
			S_TCMP: begin
				if (conv) begin
					state_d = S_IDLE;
					finish  = 1'b1;
				end else if (phase_q == PH_MID &&
					iter_q == pbr_pkg::ITER_W'(pbr_pkg::MAX_ITER)) begin
					state_d    = S_IDLE;
					finish     = 1'b1;
					fin_status = pbr_pkg::ST_CAP;
				end else begin
					state_d = S_HALVE;
				end
			end
			S_HALVE:  state_d = S_SETUP;
			default:  state_d = S_IDLE;
		endcase
	end

	// Sequencer and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_LEFT;
			k_q       <= '0;
			iter_q    <= '0;
			done_q    <= 1'b0;
			fl_neg_q  <= 1'b0;
			fl_zero_q <= 1'b0;
			coef_q[4] <= pbr_pkg::COEF_X4_RST;
			coef_q[3] <= pbr_pkg::COEF_X3_RST;
			coef_q[2] <= pbr_pkg::COEF_X2_RST;
			coef_q[1] <= pbr_pkg::COEF_X1_RST;
			coef_q[0] <= pbr_pkg::COEF_X0_RST;
			tol_q     <= pbr_pkg::TOL_RST;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						phase_q <= PH_LEFT;
						iter_q  <= '0;
					end
				end
				S_SETUP: begin
					k_q <= pbr_pkg::K_W'(pbr_pkg::NUM_COEF - 2);
				end
				S_ADD: begin
					if (k_q != '0) begin
						k_q <= k_q - 1'b1;
					end
				end
				S_EVDONE: begin
					if (phase_q == PH_LEFT) begin
						fl_neg_q  <= fneg;
						fl_zero_q <= fzero;
						phase_q   <= PH_RIGHT;
					end
				end
				S_TCMP: begin
					phase_q <= PH_MID;
				end
				S_HALVE: begin
					iter_q <= iter_q + 1'b1;
				end
				default: begin
				end
			endcase
			if (wr_en) begin
				case (wr_index)
					pbr_pkg::REG_COEF_X4: coef_q[4] <= wr_data;
					pbr_pkg::REG_COEF_X3: coef_q[3] <= wr_data;
					pbr_pkg::REG_COEF_X2: coef_q[2] <= wr_data;
					pbr_pkg::REG_COEF_X1: coef_q[1] <= wr_data;
					pbr_pkg::REG_COEF_X0: coef_q[0] <= wr_data;
					pbr_pkg::REG_TOL:     tol_q     <= wr_data;
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					left_q  <= left_end;
					right_q <= right_end;
					x_q     <= left_end;
				end
			end
			S_SETUP: begin
				acc_q  <= acc_init;
				bmag_q <= xmag_d;
				xneg_q <= x_q[31];
			end
			S_ABS: begin
				amag_q <= amag_d;
				pneg_q <= acc_q[63] ^ xneg_q;
			end
			S_MHI: begin
				plo_q <= mul_prod;
			end
			S_RND: begin
				r_q <= r_d;
			end
			S_ADD: begin
				acc_q <= acc_add;
			end
			S_EVDONE: begin
				case (phase_q)
					PH_LEFT: begin
						x_q <= right_q;
					end
					PH_RIGHT: begin
						mid_q  <= left_q;
						prev_q <= right_q;
					end
					default: begin
						// The endpoint whose value has the sign of p(mid) moves to mid.
						if (fneg != fl_neg_q) begin
							right_q <= mid_q;
						end else begin
							left_q <= mid_q;
						end
					end
				endcase
			end
			S_TABS: begin
				mmag_q <= mmag_d;
				dif_q  <= dif_d;
			end
			S_TMUL: begin
				dmag_q <= dmag_d;
			end
			S_HALVE: begin
				prev_q <= mid_q;
				mid_q  <= sum33[32:1];
				x_q    <= sum33[32:1];
			end
			default: begin
			end
		endcase
		if (finish) begin
			root_q     <= fin_root;
			status_q   <= fin_status;
			iter_out_q <= iter_q;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign root       = root_q;
	assign status     = status_q;
	assign iterations = iter_out_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after a bracket transfer");

	a_bracket_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == pbr_pkg::ST_BRACKET |-> root == 32'sd0 && iterations == 7'd0)
		else $error("wrong bracket result carries a root or iterations");

	a_cap_iter: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == pbr_pkg::ST_CAP |-> iterations == 7'(pbr_pkg::MAX_ITER))
		else $error("iteration cap reported at the wrong count");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADD |-> k_q < pbr_pkg::K_W'(pbr_pkg::NUM_COEF - 1))
		else $error("Horner step index out of range");

endmodule

/* bench/pbr_checker.sv */
// Result checker for poly_bisection_root: tracks register writes, works out the
// expected root, status and iteration count of each bracket and compares them.
// Depends on pbr_pkg for register indexes, status codes and reset values.
module pbr_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] left_end,
	input  logic signed [31:0] right_end,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               done,
	input  logic signed [31:0] root,
	input  logic [1:0]         status,
	input  logic [6:0]         iterations,
	output int                 fail_count,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Wide enough to hold a Q24.40 value times a Q8.24 value exactly.
	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic signed [31:0] root;
		logic [1:0]         status;
		logic [6:0]         iterations;
	} root_report_t;

	localparam wide_t ACC_LIMIT = {64'd0, pbr_pkg::SAT_POS};

	logic signed [31:0] coef_by_power [0:pbr_pkg::NUM_COEF-1] =
		'{pbr_pkg::COEF_X0_RST, pbr_pkg::COEF_X1_RST, pbr_pkg::COEF_X2_RST,
		  pbr_pkg::COEF_X3_RST, pbr_pkg::COEF_X4_RST};
	logic [31:0]        tol_reg = pbr_pkg::TOL_RST;
	root_report_t       expected_roots [$];
	int                 mismatches = 0;
	int                 queued = 0;

	assign fail_count  = mismatches;
	assign outstanding = queued;

	// Horner evaluation in Q24.40; each product is truncated toward zero and
	// both the product and the sum saturate symmetrically.
	function automatic wide_t horner_value(wide_t x);
		wide_t acc, prod, mag, term, cterm;
		int    k;
		acc = coef_by_power[pbr_pkg::DEGREE];
		acc = acc <<< 16;
		for (k = pbr_pkg::DEGREE - 1; k >= 0; k--) begin
			prod = acc * x;
			mag  = (prod < 0) ? -prod : prod;
			mag  = mag >>> 24;
			if (mag > ACC_LIMIT)
				mag = ACC_LIMIT;
			term  = (prod < 0) ? -mag : mag;
			cterm = coef_by_power[k];
			acc   = term + (cterm <<< 16);
			if (acc > ACC_LIMIT)
				acc = ACC_LIMIT;
			else if (acc < -ACC_LIMIT)
				acc = -ACC_LIMIT;
		end
		return acc;
	endfunction

	// Relative step test, tolerance in percent scaled by 2^32.
	function automatic bit within_tolerance(wide_t mid, wide_t prev);
		wide_t step, scale, tol_w;
		step  = (mid > prev) ? mid - prev : prev - mid;
		scale = (mid < 0) ? -mid : mid;
		tol_w = tol_reg;
		return ((step * 100) <<< 32) < (tol_w * scale);
	endfunction

	function automatic root_report_t solve_bracket(logic signed [31:0] le,
	                                               logic signed [31:0] re);
		wide_t        lo, hi, mid, prev, f_lo, f_hi, f_mid;
		int           n;
		root_report_t res;
		lo   = le;
		hi   = re;
		f_lo = horner_value(lo);
		f_hi = horner_value(hi);
		res.root       = '0;
		res.status     = pbr_pkg::ST_BRACKET;
		res.iterations = '0;
		if (f_lo != 0 && f_hi != 0 && ((f_lo < 0) != (f_hi < 0))) begin
			mid = lo;
			prev = hi;
			n = 0;
			res.status = pbr_pkg::ST_CAP;
			if (within_tolerance(mid, prev)) begin
				res.status = pbr_pkg::ST_OK;
			end else begin
				while (n < pbr_pkg::MAX_ITER) begin
					prev  = mid;
					mid   = (lo + hi) >>> 1;
					n++;
					f_mid = horner_value(mid);
					if (f_mid == 0) begin
						res.status = pbr_pkg::ST_OK;
						break;
					end
					if ((f_mid < 0) != (f_lo < 0)) begin
						hi = mid;
					end else begin
						lo   = mid;
						f_lo = f_mid;
					end
					if (within_tolerance(mid, prev)) begin
						res.status = pbr_pkg::ST_OK;
						break;
					end
				end
			end
			res.root       = mid[31:0];
			res.iterations = n[6:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		root_report_t want;
		if (!arst_n) begin
			coef_by_power[4] = pbr_pkg::COEF_X4_RST;
			coef_by_power[3] = pbr_pkg::COEF_X3_RST;
			coef_by_power[2] = pbr_pkg::COEF_X2_RST;
			coef_by_power[1] = pbr_pkg::COEF_X1_RST;
			coef_by_power[0] = pbr_pkg::COEF_X0_RST;
			tol_reg = pbr_pkg::TOL_RST;
			expected_roots.delete();
		end else begin
			if (wr_en) begin
				case (wr_index)
					pbr_pkg::REG_COEF_X4: coef_by_power[4] = wr_data;
					pbr_pkg::REG_COEF_X3: coef_by_power[3] = wr_data;
					pbr_pkg::REG_COEF_X2: coef_by_power[2] = wr_data;
					pbr_pkg::REG_COEF_X1: coef_by_power[1] = wr_data;
					pbr_pkg::REG_COEF_X0: coef_by_power[0] = wr_data;
					pbr_pkg::REG_TOL:     tol_reg = wr_data;
					default: ;
				endcase
			end
			// The result leaving is compared before a bracket entering in the
			// same cycle is queued behind it.
			if (done) begin
				if (expected_roots.size() == 0) begin
					$error("result with no bracket outstanding: root %0d status %0d iterations %0d",
					       root, status, iterations);
					mismatches++;
				end else begin
					want = expected_roots.pop_front();
					if (root !== want.root) begin
						$error("root: expected %0d, got %0d", want.root, root);
						mismatches++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (iterations !== want.iterations) begin
						$error("iterations: expected %0d, got %0d",
						       want.iterations, iterations);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				expected_roots.insert(expected_roots.size(),
				                      solve_bracket(left_end, right_end));
		end
		queued = expected_roots.size();
	end

endmodule

/* bench/tb.sv */
// Top of the poly_bisection_root bench: clock, reset, register writes and bracket
// transfers, directed cases first and then random polynomials, most built from roots.
// Depends on pbr_pkg, poly_bisection_root and pbr_checker, which does the checking.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam real        Q_SCALE       = 16777216.0;
	localparam logic [2:0] REG_SPARE_LO  = 3'd6;
	localparam logic [2:0] REG_SPARE_HI  = 3'd7;
	localparam int         RANDOM_PHASES = 12;
	localparam int         PHASE_ITEMS   = 120;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic signed [31:0] left_end  = '0;
	logic signed [31:0] right_end = '0;
	logic               wr_en     = 1'b0;
	logic [2:0]         wr_index  = pbr_pkg::REG_COEF_X4;
	logic [31:0]        wr_data   = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] root;
	logic [1:0]         status;
	logic [6:0]         iterations;
	int                 fail_count;
	int                 outstanding;

	// Roots of the current polynomial, used to aim brackets at sign changes.
	real zero_at [0:3];
	int  poly_degree = 1;
	int  burst_left  = 0;
	bit  bursty      = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	poly_bisection_root dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.left_end(left_end), .right_end(right_end),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .root(root), .status(status), .iterations(iterations)
	);

	pbr_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.left_end(left_end), .right_end(right_end),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .root(root), .status(status), .iterations(iterations),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	function automatic real uniform(real lo, real hi);
		return lo + (hi - lo) * $itor($urandom_range(0, 1000000)) / 1.0e6;
	endfunction

	function automatic real magnitude(real v);
		return (v < 0.0) ? -v : v;
	endfunction

	function automatic logic [31:0] to_q(real v);
		if (v >= 128.0)
			return 32'h7FFF_FFFF;
		if (v <= -128.0)
			return 32'h8000_0000;
		return $rtoi(v * Q_SCALE);
	endfunction

	// All tasks below are entered and left at a falling edge.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_coefs(input logic [31:0] c4, input logic [31:0] c3,
	                         input logic [31:0] c2, input logic [31:0] c1,
	                         input logic [31:0] c0);
		write_reg(pbr_pkg::REG_COEF_X4, c4);
		write_reg(pbr_pkg::REG_COEF_X3, c3);
		write_reg(pbr_pkg::REG_COEF_X2, c2);
		write_reg(pbr_pkg::REG_COEF_X1, c1);
		write_reg(pbr_pkg::REG_COEF_X0, c0);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0 || busy);
	endtask

	task automatic idle_gap(input int cycles);
		start     <= 1'b0;
		left_end  <= $urandom();
		right_end <= $urandom();
		repeat (cycles) @(negedge clk);
	endtask

	task automatic send_bracket(input logic [31:0] l, input logic [31:0] r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (bursty)
				idle_gap($urandom_range(1, 12));
		end
		burst_left--;
		start     <= 1'b1;
		left_end  <= l;
		right_end <= r;
		// The transfer happens at the first rising edge that sees busy low.
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Scaled product of (x - r) over random roots; on a grid of quarters the
	// coefficients are often exact, so midpoints can hit a zero exactly.
	task automatic load_root_poly(input bit grid);
		real c [0:4];
		real biggest, gain;
		int  k, i;
		poly_degree = $urandom_range(1, pbr_pkg::DEGREE);
		for (k = 0; k <= pbr_pkg::DEGREE; k++)
			c[k] = 0.0;
		c[0] = 1.0;
		for (i = 0; i < poly_degree; i++) begin
			zero_at[i] = grid ? 0.25 * $itor($urandom_range(0, 40)) - 5.0
			                  : uniform(-5.0, 5.0);
			for (k = i + 1; k >= 1; k--)
				c[k] = c[k-1] - zero_at[i] * c[k];
			c[0] = -zero_at[i] * c[0];
		end
		biggest = 0.0;
		for (k = 0; k <= pbr_pkg::DEGREE; k++)
			if (magnitude(c[k]) > biggest)
				biggest = magnitude(c[k]);
		gain = (biggest > 100.0) ? 100.0 / biggest : 1.0;
		if ($urandom_range(0, 3) == 0)
			gain = gain * 0.05;
		if ($urandom_range(0, 1) == 1)
			gain = -gain;
		set_coefs(to_q(gain * c[4]), to_q(gain * c[3]), to_q(gain * c[2]),
		          to_q(gain * c[1]), to_q(gain * c[0]));
	endtask

	// Bracket around one root, kept clear of its neighbors.
	task automatic send_root_bracket();
		int  i, j;
		real span, lo, hi;
		i = $urandom_range(0, poly_degree - 1);
		span = 4.0;
		for (j = 0; j < poly_degree; j++)
			if (j != i && magnitude(zero_at[j] - zero_at[i]) < span)
				span = magnitude(zero_at[j] - zero_at[i]);
		lo = zero_at[i] - 0.49 * span * uniform(0.001, 1.0);
		hi = zero_at[i] + 0.49 * span * uniform(0.001, 1.0);
		if ($urandom_range(0, 3) == 0)
			send_bracket(to_q(hi), to_q(lo));
		else
			send_bracket(to_q(lo), to_q(hi));
	endtask

	task automatic send_phase_item(input bit shaped);
		int pick;
		pick = $urandom_range(0, 19);
		if (shaped && pick < 15)
			send_root_bracket();
		else if (pick < 17)
			send_bracket(to_q(uniform(-8.0, 8.0)), to_q(uniform(-8.0, 8.0)));
		else
			send_bracket($urandom(), $urandom());
	endtask

	initial begin
		int  phase, n, pick;
		bit  shaped;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset polynomial: rejected, reversed and full-range brackets.
		send_bracket(to_q(0.0), to_q(0.0));
		send_bracket(to_q(0.0), to_q(2.0));
		send_bracket(to_q(-2.0), to_q(0.0));
		send_bracket(to_q(1.0), to_q(1.5));
		send_bracket(32'h8000_0000, 32'h7FFF_FFFF);
		send_bracket(32'h7FFF_FFFF, 32'h8000_0000);

		// x - 1: exact zero at the first midpoint, zero endpoint, zero midpoint.
		wait_drained();
		set_coefs(to_q(0.0), to_q(0.0), to_q(0.0), to_q(1.0), to_q(-1.0));
		send_bracket(to_q(0.0), to_q(2.0));
		send_bracket(to_q(1.0), to_q(3.0));
		send_bracket(to_q(3.0), to_q(0.0));
		send_bracket(to_q(-2.0), to_q(2.0));
		send_bracket(32'h8000_0000, 32'h7FFF_FFFF);

		// Loosest tolerance: a narrow bracket counts as converged up front.
		wait_drained();
		write_reg(pbr_pkg::REG_TOL, 32'hFFFF_FFFF);
		send_bracket(to_q(0.999), to_q(1.001));
		send_bracket(to_q(0.5), to_q(1.7));

		// x^2 - 2 with zero tolerance runs into the iteration cap.
		wait_drained();
		set_coefs(to_q(0.0), to_q(0.0), to_q(1.0), to_q(0.0), to_q(-2.0));
		write_reg(pbr_pkg::REG_TOL, 32'h0);
		send_bracket(to_q(1.0), to_q(2.0));
		send_bracket(to_q(-2.0), to_q(-1.0));
		send_bracket(to_q(0.0), to_q(2.0));

		// Extreme coefficients drive the accumulator into saturation.
		wait_drained();
		set_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
		          32'h8000_0000);
		write_reg(pbr_pkg::REG_TOL, pbr_pkg::TOL_RST);
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		send_bracket(to_q(0.0), 32'h7FFF_FFFF);
		send_bracket(32'h8000_0000, to_q(0.0));
		send_bracket(32'h8000_0000, 32'h7FFF_FFFF);
		send_bracket(to_q(0.0), to_q(2.0));
		wait_drained();
		set_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h0);
		send_bracket(to_q(0.0), 32'h7FFF_FFFF);
		send_bracket(32'h8000_0000, to_q(0.0));

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			shaped = (phase % 4 != 3);
			if (shaped)
				load_root_poly(phase % 2 == 1);
			else
				set_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
			pick = $urandom_range(0, 7);
			case (pick)
				0:       write_reg(pbr_pkg::REG_TOL, 32'h0);
				1:       write_reg(pbr_pkg::REG_TOL, 32'hFFFF_FFFF);
				2:       write_reg(pbr_pkg::REG_TOL, $urandom());
				default: write_reg(pbr_pkg::REG_TOL, $urandom_range(1, 4194304));
			endcase
			if (phase % 3 == 0)
				write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO,
				          $urandom());
			bursty = (phase % 5 != 2);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_phase_item(shaped);
				if ($urandom_range(0, 99) == 0)
					wait_drained();
			end
		end

		wait_drained();
		// Long enough for a stray result from a slow bracket to show up.
		repeat (2000) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
